### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the draw engine modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled at the clock, off while in reset
`define ZRPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ZRPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/zrpd_pkg.sv
// ---------------------------------------------------------------------------
// zrpd_pkg
// types, constants and the control store of the zoomed rectangle draw engine
// ---------------------------------------------------------------------------
package zrpd_pkg;

	localparam int FB_WIDTH  = 256;
	localparam int FB_HEIGHT = 256;
	localparam int MAX_ZOOM  = 16;

	localparam int FB_WORDS  = FB_WIDTH * FB_HEIGHT;
	localparam int FB_ADDR_W = $clog2(FB_WORDS);

	localparam int ZOOM_W  = 5;
	localparam int SIZE_W  = 9;
	localparam int COORD_W = 20;
	localparam int PC_W    = 4;

	localparam logic [31:0] BLACK_WORD = 32'hFF00_0000;
	localparam logic [31:0] WHITE_WORD = 32'h00FF_FFFF;
	localparam logic [7:0]  OPAQUE_BYTE = 8'hFF;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [1:0] {
		ACT_RECT  = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_ZOOM   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_ADJ   = 4'd0,  // fold a negative rect x into its width
		OP_MXB   = 4'd1,  // xb = x * zoom
		OP_MXE   = 4'd2,  // xe = (x + w) * zoom
		OP_MYB   = 4'd3,  // yb = y * zoom
		OP_BOX   = 4'd4,  // clipped box fill
		OP_RADDR = 4'd5,  // read address and range check
		OP_RREAD = 4'd6,  // frame store read
		OP_EMIT  = 4'd7   // load result register
	} op_t;

	typedef enum logic [2:0] {
		CS_XB   = 3'd0,
		CS_XB1  = 3'd1,
		CS_XE   = 3'd2,
		CS_XEM1 = 3'd3,
		CS_XBZ  = 3'd4,
		CS_ZERO = 3'd5,
		CS_AW   = 3'd6
	} csel_t;

	typedef enum logic [2:0] {
		RS_YB    = 3'd0,
		RS_YB1   = 3'd1,
		RS_YBZ   = 3'd2,
		RS_YBZM1 = 3'd3,
		RS_ZERO  = 3'd4,
		RS_AH    = 3'd5
	} rsel_t;

	typedef enum logic [1:0] {
		WD_BLACK = 2'd0,
		WD_COLOR = 2'd1,
		WD_WHITE = 2'd2
	} wsel_t;

	typedef enum logic [1:0] {
		WT_NONE = 2'd0,
		WT_BOX  = 2'd1,
		WT_OUT  = 2'd2
	} wait_t;

	typedef enum logic {
		CND_NONE   = 1'b0,
		CND_RD_OUT = 1'b1
	} cond_t;

	typedef struct packed {
		op_t   op;
		csel_t c0;
		csel_t c1;
		rsel_t r0;
		rsel_t r1;
		wsel_t wd;
		wait_t wt;
		cond_t cnd;
		pc_t   target;
		logic  last;
	} ctrl_word_t;

	typedef struct packed {
		logic box_done;
		logic out_free;
		logic rd_out;
	} seq_stat_t;

	typedef struct packed {
		logic        start;
		coord_t      c0;
		coord_t      c1;
		coord_t      r0;
		coord_t      r1;
		logic [31:0] word;
	} box_cmd_t;

	typedef struct packed {
		logic                 we;
		logic [FB_ADDR_W-1:0] addr;
		logic [31:0]          data;
	} fb_wr_t;

	localparam pc_t EP_RECT  = 4'd0;
	localparam pc_t EP_PIXEL = 4'd9;
	localparam pc_t EP_CLEAR = 4'd12;
	localparam pc_t EP_READ  = 4'd13;
	localparam pc_t PC_EMIT  = 4'd15;

	function automatic ctrl_word_t mk_cw(op_t op, csel_t c0, csel_t c1, rsel_t r0, rsel_t r1,
			wsel_t wd, wait_t wt, cond_t cnd, pc_t tgt, logic last);
		ctrl_word_t w;
		w.op     = op;
		w.c0     = c0;
		w.c1     = c1;
		w.r0     = r0;
		w.r1     = r1;
		w.wd     = wd;
		w.wt     = wt;
		w.cnd    = cnd;
		w.target = tgt;
		w.last   = last;
		return w;
	endfunction

	function automatic ctrl_word_t mk_op(op_t op, wait_t wt, cond_t cnd, pc_t tgt, logic last);
		return mk_cw(op, CS_ZERO, CS_ZERO, RS_ZERO, RS_ZERO, WD_BLACK, wt, cnd, tgt, last);
	endfunction

	function automatic ctrl_word_t mk_box(csel_t c0, csel_t c1, rsel_t r0, rsel_t r1,
			wsel_t wd, logic last);
		return mk_cw(OP_BOX, c0, c1, r0, r1, wd, WT_BOX, CND_NONE, EP_RECT, last);
	endfunction

	// control store
	function automatic ctrl_word_t ucode(pc_t pc);
		ctrl_word_t w;
		unique case (pc)
			// draw_rect: border rows, border columns, interior
			4'd0:  w = mk_op(OP_ADJ, WT_NONE, CND_NONE, EP_RECT, 1'b0);
			4'd1:  w = mk_op(OP_MXB, WT_NONE, CND_NONE, EP_RECT, 1'b0);
			4'd2:  w = mk_op(OP_MXE, WT_NONE, CND_NONE, EP_RECT, 1'b0);
			4'd3:  w = mk_op(OP_MYB, WT_NONE, CND_NONE, EP_RECT, 1'b0);
			4'd4:  w = mk_box(CS_XB,   CS_XE,   RS_YB,    RS_YB1,   WD_BLACK, 1'b0);
			4'd5:  w = mk_box(CS_XB,   CS_XE,   RS_YBZM1, RS_YBZ,   WD_BLACK, 1'b0);
			4'd6:  w = mk_box(CS_XB,   CS_XB1,  RS_YB,    RS_YBZ,   WD_BLACK, 1'b0);
			4'd7:  w = mk_box(CS_XEM1, CS_XE,   RS_YB,    RS_YBZ,   WD_BLACK, 1'b0);
			4'd8:  w = mk_box(CS_XB1,  CS_XEM1, RS_YB1,   RS_YBZM1, WD_COLOR, 1'b1);
			// draw_pixel
			4'd9:  w = mk_op(OP_MXB, WT_NONE, CND_NONE, EP_RECT, 1'b0);
			4'd10: w = mk_op(OP_MYB, WT_NONE, CND_NONE, EP_RECT, 1'b0);
			4'd11: w = mk_box(CS_XB,   CS_XBZ,  RS_YB,    RS_YBZ,   WD_COLOR, 1'b1);
			// clear
			4'd12: w = mk_box(CS_ZERO, CS_AW,   RS_ZERO,  RS_AH,    WD_WHITE, 1'b1);
			// read_pixel: skip the store read when out of range
			4'd13: w = mk_op(OP_RADDR, WT_NONE, CND_RD_OUT, PC_EMIT, 1'b0);
			4'd14: w = mk_op(OP_RREAD, WT_NONE, CND_NONE, EP_RECT, 1'b0);
			4'd15: w = mk_op(OP_EMIT,  WT_OUT,  CND_NONE, EP_RECT, 1'b1);
			default: w = mk_op(OP_EMIT, WT_NONE, CND_NONE, EP_RECT, 1'b1);
		endcase
		return w;
	endfunction

	function automatic pc_t entry_pc(action_t act);
		pc_t p;
		unique case (act)
			ACT_RECT:  p = EP_RECT;
			ACT_PIXEL: p = EP_PIXEL;
			ACT_CLEAR: p = EP_CLEAR;
			ACT_READ:  p = EP_READ;
			default:   p = EP_READ;
		endcase
		return p;
	endfunction

endpackage

### sv/zoomed_rect_pixel_draw_engine.sv
// ---------------------------------------------------------------------------
// zoomed_rect_pixel_draw_engine
// zoomed rectangle and pixel drawing into a clipped 32-bit frame store
// ---------------------------------------------------------------------------
// channel | dir | tdata / data                          | tuser
// s_      | in  | pos_x, pos_y, rect_width, fill_color  | action
// m_      | out | pixel_word                            | in_range
// cfg_    | in  | cfg_index, cfg_data (register write)  | -
//
// after reset a clearing pass writes white to all 65536 words; s_tready stays
// low until it ends, config writes are taken throughout.
// one command at a time; a box fill clips the box, sets up the row base, then
// sweeps the written pixels row by row, and a box clipped away ends after the
// clip step; draw_pixel fills one box of zoom^2 pixels before clipping,
// draw_rect the clipped pixels of its five boxes and clear one box of aw * ah.
// read_pixel skips the store read out of range, waits while m_ stalls the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module zoomed_rect_pixel_draw_engine
	import zrpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_x[12:0], pos_y[24:13], rect_width[37:25], fill_color[61:38]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pixel_word[31:0]
	output logic [0:0]  m_tuser,   // in_range[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	logic [ZOOM_W-1:0]    zoom_q;
	logic [SIZE_W-1:0]    aw_q, ah_q;

	logic signed [14:0]   xs_q, ws_q;
	logic [11:0]          y_q;
	logic [23:0]          color_q;
	coord_t               xb_q, xe_q, yb_q;
	logic                 rin_q;
	logic [FB_ADDR_W-1:0] raddr_q;

	logic                 out_valid_q;
	logic [31:0]          pixel_q;
	logic                 in_range_q;

	logic                 started_q;

	ctrl_word_t           cw;
	logic                 run, adv, accept, init_done;
	seq_stat_t            stat;
	box_cmd_t             bcmd;
	fb_wr_t               wr;
	logic                 box_done;
	logic [31:0]          rd_data;
	logic                 rd_en, out_free, out_load;

	logic signed [14:0]   mul_a;
	logic signed [20:0]   mul_p;
	coord_t               zoom_c, aw_c, ah_c;
	logic                 rin_d;
	logic [16:0]          rprod;
	logic [FB_ADDR_W-1:0] raddr_d;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q <= ZOOM_W'(1);
			aw_q   <= SIZE_W'(FB_WIDTH);
			ah_q   <= SIZE_W'(FB_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			// saturate on write: the registers hold the effective values
			case (cfg_index)
				REG_ZOOM: begin
					if (cfg_data[4:0] == '0) begin
						zoom_q <= ZOOM_W'(1);
					end else if (cfg_data[4:0] > ZOOM_W'(MAX_ZOOM)) begin
						zoom_q <= ZOOM_W'(MAX_ZOOM);
					end else begin
						zoom_q <= cfg_data[4:0];
					end
				end
				REG_WIDTH: begin
					if (cfg_data == '0) begin
						aw_q <= SIZE_W'(1);
					end else if (cfg_data > SIZE_W'(FB_WIDTH)) begin
						aw_q <= SIZE_W'(FB_WIDTH);
					end else begin
						aw_q <= cfg_data;
					end
				end
				REG_HEIGHT: begin
					if (cfg_data == '0) begin
						ah_q <= SIZE_W'(1);
					end else if (cfg_data > SIZE_W'(FB_HEIGHT)) begin
						ah_q <= SIZE_W'(FB_HEIGHT);
					end else begin
						ah_q <= cfg_data;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	assign s_tready = !run && init_done;
	assign accept   = s_tvalid && s_tready;

	assign out_free = !out_valid_q || m_tready;

	assign stat.box_done = box_done;
	assign stat.out_free = out_free;
	assign stat.rd_out   = !rin_d;

	zrpd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.action (action_t'(s_tuser)),
		.stat   (stat),
		.cw     (cw),
		.run    (run),
		.adv    (adv)
	);

	// ---------------- operand datapath ----------------
	assign zoom_c = $signed({{(COORD_W-ZOOM_W){1'b0}}, zoom_q});
	assign aw_c   = $signed({{(COORD_W-SIZE_W){1'b0}}, aw_q});
	assign ah_c   = $signed({{(COORD_W-SIZE_W){1'b0}}, ah_q});

	always_comb begin
		unique case (cw.op)
			OP_MXE:  mul_a = xs_q + ws_q;
			OP_MYB:  mul_a = $signed({3'b000, y_q});
			default: mul_a = xs_q;
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, zoom_q});

	assign rin_d   = !xs_q[14] && (xs_q[13:0] < 14'(aw_q)) && (y_q < 12'(ah_q));
	assign rprod   = 17'(y_q[7:0]) * 17'(aw_q);
	assign raddr_d = rprod[FB_ADDR_W-1:0] + FB_ADDR_W'(xs_q[7:0]);

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_q    <= 15'(signed'(s_tdata[12:0]));
			y_q     <= s_tdata[24:13];
			ws_q    <= $signed({2'b00, s_tdata[37:25]});
			color_q <= s_tdata[61:38];
		end else if (run) begin
			case (cw.op)
				OP_ADJ: begin
					// negative x shortens the width and starts at column zero
					if (xs_q[14]) begin
						ws_q <= ws_q + xs_q;
						xs_q <= '0;
					end
				end
				OP_MXB:   xb_q <= mul_p[COORD_W-1:0];
				OP_MXE:   xe_q <= mul_p[COORD_W-1:0];
				OP_MYB:   yb_q <= mul_p[COORD_W-1:0];
				OP_RADDR: begin
					rin_q   <= rin_d;
					raddr_q <= raddr_d;
				end
				default: ;
			endcase
		end
	end

	// ---------------- box command ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (bcmd.start) begin
			started_q <= 1'b1;
		end else if (adv) begin
			started_q <= 1'b0;
		end
	end

	assign bcmd.start = run && (cw.op == OP_BOX) && !started_q;

	always_comb begin
		unique case (cw.c0)
			CS_XB:   bcmd.c0 = xb_q;
			CS_XB1:  bcmd.c0 = xb_q + 1'b1;
			CS_XE:   bcmd.c0 = xe_q;
			CS_XEM1: bcmd.c0 = xe_q - 1'b1;
			CS_XBZ:  bcmd.c0 = xb_q + zoom_c;
			CS_AW:   bcmd.c0 = aw_c;
			default: bcmd.c0 = '0;
		endcase
		unique case (cw.c1)
			CS_XB:   bcmd.c1 = xb_q;
			CS_XB1:  bcmd.c1 = xb_q + 1'b1;
			CS_XE:   bcmd.c1 = xe_q;
			CS_XEM1: bcmd.c1 = xe_q - 1'b1;
			CS_XBZ:  bcmd.c1 = xb_q + zoom_c;
			CS_AW:   bcmd.c1 = aw_c;
			default: bcmd.c1 = '0;
		endcase
		unique case (cw.r0)
			RS_YB:    bcmd.r0 = yb_q;
			RS_YB1:   bcmd.r0 = yb_q + 1'b1;
			RS_YBZ:   bcmd.r0 = yb_q + zoom_c;
			RS_YBZM1: bcmd.r0 = yb_q + zoom_c - 1'b1;
			RS_AH:    bcmd.r0 = ah_c;
			default:  bcmd.r0 = '0;
		endcase
		unique case (cw.r1)
			RS_YB:    bcmd.r1 = yb_q;
			RS_YB1:   bcmd.r1 = yb_q + 1'b1;
			RS_YBZ:   bcmd.r1 = yb_q + zoom_c;
			RS_YBZM1: bcmd.r1 = yb_q + zoom_c - 1'b1;
			RS_AH:    bcmd.r1 = ah_c;
			default:  bcmd.r1 = '0;
		endcase
		unique case (cw.wd)
			WD_COLOR: bcmd.word = {OPAQUE_BYTE, color_q};
			WD_WHITE: bcmd.word = WHITE_WORD;
			default:  bcmd.word = BLACK_WORD;
		endcase
	end

	zrpd_box u_box (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bcmd),
		.aw     (aw_q),
		.ah     (ah_q),
		.done   (box_done),
		.wr     (wr)
	);

	// ---------------- frame store ----------------
	assign rd_en = run && (cw.op == OP_RREAD);

	zrpd_fb u_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_en     (rd_en),
		.rd_addr   (raddr_q),
		.rd_data   (rd_data),
		.init_done (init_done)
	);

	// ---------------- result register ----------------
	assign out_load = run && (cw.op == OP_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_q    <= rin_q ? rd_data : 32'h0;
			in_range_q <= rin_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = pixel_q;
	assign m_tuser[0] = in_range_q;

	`ZRPD_ASSERT_IMP(a_no_draw_in_init, wr.we, init_done, "box write during clearing pass")

endmodule

### sv/zrpd_fb.sv
// ---------------------------------------------------------------------------
// zrpd_fb
// frame store with one write and one registered read port, white after reset
// ---------------------------------------------------------------------------
module zrpd_fb
	import zrpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  fb_wr_t               wr,
	input  logic                 rd_en,
	input  logic [FB_ADDR_W-1:0] rd_addr,
	output logic [31:0]          rd_data,
	output logic                 init_done
);

	logic [31:0]          mem [FB_WORDS];
	logic                 clr_busy_q;
	logic [FB_ADDR_W-1:0] clr_addr_q;
	logic                 we;
	logic [FB_ADDR_W-1:0] waddr;
	logic [31:0]          wdata;
	logic [31:0]          rd_data_q;

	// clearing pass: one word per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = WHITE_WORD;
		end else begin
			we    = wr.we;
			waddr = wr.addr;
			wdata = wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data   = rd_data_q;
	assign init_done = !clr_busy_q;

endmodule

### sv/zrpd_box.sv
// ---------------------------------------------------------------------------
// zrpd_box
// clips a box to the active area and sweeps it row by row into the store
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module zrpd_box
	import zrpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  box_cmd_t          cmd,
	input  logic [SIZE_W-1:0] aw,
	input  logic [SIZE_W-1:0] ah,
	output logic              done,
	output fb_wr_t            wr
);

	typedef enum logic [3:0] {
		BX_IDLE  = 4'b0001,
		BX_CLIP  = 4'b0010,
		BX_BASE  = 4'b0100,
		BX_SWEEP = 4'b1000
	} bx_state_t;

	bx_state_t            state_q;
	coord_t               c0_q, c1_q, r0_q, r1_q;
	logic [31:0]          word_q;
	logic [SIZE_W-1:0]    cs_q, ce_q, c_q, r_q, re_q;
	logic [FB_ADDR_W-1:0] rowbase_q;

	coord_t               aw_c, ah_c, cl_c0, cl_c1, cl_r0, cl_r1;
	logic                 empty;
	logic                 col_last, row_last;
	logic [SIZE_W+7:0]    base_prod;

	always_comb begin
		aw_c  = $signed({{(COORD_W-SIZE_W){1'b0}}, aw});
		ah_c  = $signed({{(COORD_W-SIZE_W){1'b0}}, ah});
		cl_c0 = (c0_q < 0) ? '0 : c0_q;
		cl_r0 = (r0_q < 0) ? '0 : r0_q;
		cl_c1 = (c1_q > aw_c) ? aw_c : c1_q;
		cl_r1 = (r1_q > ah_c) ? ah_c : r1_q;
		empty = !(cl_c0 < cl_c1) || !(cl_r0 < cl_r1);
	end

	assign col_last  = ({1'b0, c_q} + 1'b1) == {1'b0, ce_q};
	assign row_last  = ({1'b0, r_q} + 1'b1) == {1'b0, re_q};
	assign base_prod = r_q[7:0] * aw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BX_IDLE;
		end else begin
			unique case (state_q)
				BX_IDLE:  if (cmd.start) state_q <= BX_CLIP;
				BX_CLIP:  state_q <= empty ? BX_IDLE : BX_BASE;
				BX_BASE:  state_q <= BX_SWEEP;
				BX_SWEEP: if (col_last && row_last) state_q <= BX_IDLE;
				default:  state_q <= BX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BX_IDLE && cmd.start) begin
			c0_q   <= cmd.c0;
			c1_q   <= cmd.c1;
			r0_q   <= cmd.r0;
			r1_q   <= cmd.r1;
			word_q <= cmd.word;
		end
		if (state_q == BX_CLIP) begin
			cs_q <= cl_c0[SIZE_W-1:0];
			ce_q <= cl_c1[SIZE_W-1:0];
			r_q  <= cl_r0[SIZE_W-1:0];
			re_q <= cl_r1[SIZE_W-1:0];
		end
		if (state_q == BX_BASE) begin
			rowbase_q <= base_prod[FB_ADDR_W-1:0];
			c_q       <= cs_q;
		end
		if (state_q == BX_SWEEP) begin
			if (col_last) begin
				c_q       <= cs_q;
				r_q       <= r_q + 1'b1;
				rowbase_q <= rowbase_q + FB_ADDR_W'(aw);
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	assign done    = (state_q == BX_CLIP && empty) || (state_q == BX_SWEEP && col_last && row_last);
	assign wr.we   = (state_q == BX_SWEEP);
	assign wr.addr = rowbase_q + FB_ADDR_W'(c_q);
	assign wr.data = word_q;

	`ZRPD_ASSERT_IMP(a_box_start_idle, cmd.start, state_q == BX_IDLE, "box started while busy")
	`ZRPD_ASSERT_IMP(a_box_in_bounds, state_q == BX_SWEEP, (c_q < ce_q) && (r_q < re_q), "sweep out of box")

endmodule

### sv/zrpd_seq.sv
// ---------------------------------------------------------------------------
// zrpd_seq
// step counter over the control store with waits and conditional jumps
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module zrpd_seq
	import zrpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  action_t    action,
	input  seq_stat_t  stat,
	output ctrl_word_t cw,
	output logic       run,
	output logic       adv
);

	typedef enum logic [1:0] {
		SQ_IDLE = 2'b01,
		SQ_RUN  = 2'b10
	} sq_state_t;

	sq_state_t state_q;
	pc_t       pc_q;
	logic      ok, take;

	assign cw = ucode(pc_q);

	always_comb begin
		unique case (cw.wt)
			WT_NONE: ok = 1'b1;
			WT_BOX:  ok = stat.box_done;
			WT_OUT:  ok = stat.out_free;
			default: ok = 1'b1;
		endcase
		take = (cw.cnd == CND_RD_OUT) && stat.rd_out;
	end

	assign run = (state_q == SQ_RUN);
	assign adv = run && ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			pc_q    <= EP_RECT;
		end else begin
			unique case (state_q)
				SQ_IDLE: begin
					if (start) begin
						pc_q    <= entry_pc(action);
						state_q <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					if (ok) begin
						if (cw.last) begin
							state_q <= SQ_IDLE;
						end else if (take) begin
							pc_q <= cw.target;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	`ZRPD_ASSERT_IMP(a_seq_start_idle, start, state_q == SQ_IDLE, "command taken while running")

endmodule
